>>> sv/hall_angle_speed_estimator_core_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk_i and rst_ni in scope.
`ifndef HALL_ANGLE_SPEED_ESTIMATOR_CORE_MACROS_SVH
`define HALL_ANGLE_SPEED_ESTIMATOR_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HASE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HASE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hase_pkg.sv
// ----------------------------------------------------------------------------
// hase_pkg
// Types, constants and sector lookup of the Hall angle and speed estimator.
// ----------------------------------------------------------------------------
package hase_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AngleW = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CntW   = 5;

  // Configuration register indexes
  localparam logic [1:0] CfgAngleFactor = 2'd0;
  localparam logic [1:0] CfgSpeedFactor = 2'd1;
  localparam logic [1:0] CfgPhaseOffset = 2'd2;

  localparam logic [DataW-1:0] Sat32 = {DataW{1'b1}};

  // Control of one bit-serial divider lane
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Sector angles, 65536 units per turn, rounded to nearest
  localparam logic [AngleW-1:0] Sector0 = 16'd0;
  localparam logic [AngleW-1:0] Sector1 = 16'd10923;
  localparam logic [AngleW-1:0] Sector2 = 16'd21845;
  localparam logic [AngleW-1:0] Sector3 = 16'd32768;
  localparam logic [AngleW-1:0] Sector4 = 16'd43691;
  localparam logic [AngleW-1:0] Sector5 = 16'd54613;

  function automatic logic [AngleW-1:0] sector_angle(input logic [CodeW-1:0] code);
    logic [AngleW-1:0] a;
    case (code)
      3'd5:    a = Sector0;
      3'd4:    a = Sector1;
      3'd6:    a = Sector2;
      3'd2:    a = Sector3;
      3'd3:    a = Sector4;
      3'd1:    a = Sector5;
      default: a = Sector0;
    endcase
    return a;
  endfunction

  // Codes with all lines low or all lines high mean no valid sector
  function automatic logic code_is_bad(input logic [CodeW-1:0] code);
    return (code == 3'd0) || (code == 3'd7);
  endfunction

endpackage

>>> sv/hase_div_lane.sv
// ----------------------------------------------------------------------------
// hase_div_lane
// Restoring divider, one quotient bit per cycle while step is asserted; the
// quotient shifts into the numerator register.
// ----------------------------------------------------------------------------
module hase_div_lane import hase_pkg::*; (
  input  logic             clk_i,
  input  div_ctrl_t        ctrl_i,
  input  logic [DataW-1:0] numer_i,
  input  logic [DataW-1:0] divisor_i,
  output logic [DataW-1:0] quot_o
);

  logic [DataW-1:0] num_q, num_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, num_q[DataW-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = (shifted >= {1'b0, divisor_i});
    num_d   = num_q;
    rem_d   = rem_q;
    if (ctrl_i.load) begin
      num_d = numer_i;
      rem_d = '0;
    end else if (ctrl_i.step) begin
      num_d = {num_q[DataW-2:0], ge};
      rem_d = ge ? diff[DataW-1:0] : shifted[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign quot_o = num_q;

endmodule

>>> sv/hall_angle_speed_estimator_core.sv
// ----------------------------------------------------------------------------
// hall_angle_speed_estimator_core
// Hall edge to rotor angle, angle step and speed, with two bit-serial dividers.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   edge_period_i, hall_code_i
// out      output     out_valid_o / out_stall_i rotor_angle_o, angle_step_o,
//                                               rotor_speed_o, bad_code_o,
//                                               zero_period_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An item passes through accept, 32 divider steps and the load of the
// output register. The divider lanes produce one quotient bit per cycle.
// A new item is accepted while the previous result still waits at the output.
// A stalled output holds the finished item in the divider state until taken.
// Reset clears control state, configuration and the held angle.
// ----------------------------------------------------------------------------
module hall_angle_speed_estimator_core import hase_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DataW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DataW-1:0]  edge_period_i,
  input  logic [CodeW-1:0]  hall_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AngleW-1:0] rotor_angle_o,
  output logic [DataW-1:0]  angle_step_o,
  output logic [DataW-1:0]  rotor_speed_o,
  output logic              bad_code_o,
  output logic              zero_period_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [DataW-1:0]  angle_factor_q, speed_factor_q;
  logic [AngleW-1:0] phase_offset_q;
  logic [AngleW-1:0] held_angle_q, held_angle_d;
  logic [DataW-1:0]  divisor_q;
  logic              bad_q, zero_q;
  logic              out_valid_q;
  logic [AngleW-1:0] out_angle_q;
  logic [DataW-1:0]  out_step_q, out_speed_q;
  logic              out_bad_q, out_zero_q;

  logic              accept;
  logic              out_free;
  logic              bad_in;
  div_ctrl_t         div_ctrl;
  logic [DataW-1:0]  step_quot, speed_quot;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign bad_in   = code_is_bad(hall_code_i);

  always_comb begin
    div_ctrl.load = accept;
    div_ctrl.step = (state_q == ST_DIV);
    held_angle_d  = held_angle_q;
    if (accept && !bad_in) begin
      held_angle_d = sector_angle(hall_code_i) + phase_offset_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_factor_q <= '0;
      speed_factor_q <= '0;
      phase_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAngleFactor: angle_factor_q <= cfg_data_i;
        CfgSpeedFactor: speed_factor_q <= cfg_data_i;
        CfgPhaseOffset: phase_offset_q <= cfg_data_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      held_angle_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      held_angle_q <= held_angle_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DataW - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      divisor_q <= edge_period_i;
      bad_q     <= bad_in;
      zero_q    <= (edge_period_i == '0);
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_angle_q <= held_angle_q;
      out_step_q  <= zero_q ? Sat32 : step_quot;
      out_speed_q <= zero_q ? Sat32 : speed_quot;
      out_bad_q   <= bad_q;
      out_zero_q  <= zero_q;
    end
  end

  hase_div_lane u_step_lane (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .numer_i   (angle_factor_q),
    .divisor_i (divisor_q),
    .quot_o    (step_quot)
  );

  hase_div_lane u_speed_lane (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .numer_i   (speed_factor_q),
    .divisor_i (divisor_q),
    .quot_o    (speed_quot)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign rotor_angle_o = out_angle_q;
  assign angle_step_o  = out_step_q;
  assign rotor_speed_o = out_speed_q;
  assign bad_code_o    = out_bad_q;
  assign zero_period_o = out_zero_q;

endmodule

>>> sv/hase_checker.sv
// ----------------------------------------------------------------------------
// hase_checker
// Port-level checks of the Hall angle and speed estimator, bound to the core.
// ----------------------------------------------------------------------------
`include "hall_angle_speed_estimator_core_macros.svh"

module hase_checker import hase_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [AngleW-1:0] rotor_angle_o,
  input logic [DataW-1:0]  angle_step_o,
  input logic [DataW-1:0]  rotor_speed_o,
  input logic              zero_period_o
);

  `HASE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(rotor_angle_o), "stalled output item dropped or changed")
  `HASE_ASSERT(a_zero_sat, !(out_valid_o && zero_period_o) ||
    ((angle_step_o == Sat32) && (rotor_speed_o == Sat32)), "zero period item not saturated")
  `HASE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "input taken again while dividing")
  `HASE_ASSERT(a_busy_two, (in_valid_i && !in_stall_o) |-> ##2 in_stall_o,
    "divider released too early")

endmodule

bind hall_angle_speed_estimator_core hase_checker u_hase_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .rotor_angle_o (rotor_angle_o),
  .angle_step_o  (angle_step_o),
  .rotor_speed_o (rotor_speed_o),
  .zero_period_o (zero_period_o)
);

>>> sim/tb_hall_angle_speed_estimator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hall_angle_speed_estimator_core
// Self-checking regression of the Hall angle and speed estimator.
// ----------------------------------------------------------------------------
// Hall edge items go in through a bursty sender and results come out through
// a receiver that stalls on its own pattern. Each accepted item is predicted
// from a shadow copy of the registers and the held angle; each result is
// compared field by field with the oldest prediction. Directed items cover
// every Hall code, zero and extreme periods, offset wrap and held angle on
// bad codes; random phases then change the registers and the idle patterns.
// ----------------------------------------------------------------------------
module tb_hall_angle_speed_estimator_core;
  import hase_pkg::*;

  localparam int unsigned LimitCycles = 600000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseItems  = 115;

  // Hall codes, bit 0 U, bit 1 V, bit 2 W
  localparam logic [CodeW-1:0] HallAllLow  = 3'b000;
  localparam logic [CodeW-1:0] HallSect0   = 3'b101;
  localparam logic [CodeW-1:0] HallSect1   = 3'b100;
  localparam logic [CodeW-1:0] HallSect2   = 3'b110;
  localparam logic [CodeW-1:0] HallSect3   = 3'b010;
  localparam logic [CodeW-1:0] HallSect4   = 3'b011;
  localparam logic [CodeW-1:0] HallSect5   = 3'b001;
  localparam logic [CodeW-1:0] HallAllHigh = 3'b111;

  // Index with no register behind it
  localparam logic [1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [DataW-1:0]  step;
    logic [DataW-1:0]  speed;
    logic              bad;
    logic              zero;
  } hall_result_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [1:0]        cfg_idx    = CfgAngleFactor;
  logic [DataW-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [DataW-1:0]  edge_period = '0;
  logic [CodeW-1:0]  hall_code  = HallAllLow;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [AngleW-1:0] rotor_angle;
  logic [DataW-1:0]  angle_step;
  logic [DataW-1:0]  rotor_speed;
  logic              bad_code;
  logic              zero_period;

  // Shadow of the block's registers and held angle
  logic [DataW-1:0]  angle_fac  = '0;
  logic [DataW-1:0]  speed_fac  = '0;
  logic [AngleW-1:0] phase_off  = '0;
  logic [AngleW-1:0] angle_hold = '0;

  hall_result_t      pending_results[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;

  // Receiver stall controls
  int unsigned       stall_pct   = 0;
  int unsigned       hold_request = 0;

  hall_angle_speed_estimator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .edge_period_i (edge_period),
    .hall_code_i   (hall_code),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .rotor_angle_o (rotor_angle),
    .angle_step_o  (angle_step),
    .rotor_speed_o (rotor_speed),
    .bad_code_o    (bad_code),
    .zero_period_o (zero_period)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count >= LimitCycles);
    $display("hall_angle_speed_estimator_core regression: fail");
    $finish;
  end

  // Advance the held angle and work out the result of one Hall edge
  function automatic hall_result_t predict_hall_event(logic [DataW-1:0] period,
                                                      logic [CodeW-1:0] code);
    hall_result_t r;
    logic [AngleW-1:0] base;
    logic valid_code;
    valid_code = 1'b1;
    case (code)
      HallSect0: base = Sector0;
      HallSect1: base = Sector1;
      HallSect2: base = Sector2;
      HallSect3: base = Sector3;
      HallSect4: base = Sector4;
      HallSect5: base = Sector5;
      default: begin
        base = '0;
        valid_code = 1'b0;
      end
    endcase
    if (valid_code) angle_hold = base + phase_off;
    r.angle = angle_hold;
    r.bad = !valid_code;
    r.zero = (period == '0);
    if (r.zero) begin
      r.step = Sat32;
      r.speed = Sat32;
    end else begin
      r.step = angle_fac / period;
      r.speed = speed_fac / period;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result checker: the stall seen at the falling edge holds at the next rising edge
  always @(negedge clk_i) begin
    hall_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, angle %0h", $time, rotor_angle);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("rotor_angle", DataW'(want.angle), DataW'(rotor_angle));
        check_field("angle_step", want.step, angle_step);
        check_field("rotor_speed", want.speed, rotor_speed);
        check_field("bad_code", DataW'(want.bad), DataW'(bad_code));
        check_field("zero_period", DataW'(want.zero), DataW'(zero_period));
      end
    end
  end

  // Receiver stall pattern: random runs, plus a long hold on request
  always @(posedge clk_i) begin
    int unsigned hold_left;
    int unsigned run_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      run_left = $urandom_range(6);
    end
  end

  task automatic send_hall_event(logic [DataW-1:0] period, logic [CodeW-1:0] code);
    in_valid <= 1'b1;
    edge_period <= period;
    hall_code <= code;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    pending_results.push_back(predict_hall_event(period, code));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CfgAngleFactor: angle_fac = data;
      CfgSpeedFactor: speed_fac = data;
      CfgPhaseOffset: phase_off = data[AngleW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic [DataW-1:0] afac, logic [DataW-1:0] sfac,
                                logic [AngleW-1:0] offset);
    write_reg(CfgAngleFactor, afac);
    write_reg(CfgSpeedFactor, sfac);
    write_reg(CfgPhaseOffset, {{(DataW-AngleW){offset[AngleW-1]}}, offset});
  endtask

  function automatic logic [DataW-1:0] rand_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return DataW'($urandom_range(1, 16));
      3:       return DataW'($urandom_range(1, 5000));
      4:       return DataW'(1) << $urandom_range(DataW-1);
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_factor();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return DataW'($urandom_range(1, 65535));
      default: return DataW'($urandom);
    endcase
  endfunction

  // Bursts of back-to-back items with random gaps between them
  task automatic send_burst_traffic(int unsigned count, int unsigned max_gap);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) send_hall_event(rand_period(), CodeW'($urandom_range(7)));
      left -= burst;
      gap = $urandom_range(max_gap);
      if (gap > 0 && left > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Registers at reset: zero factors, zero offset, held angle zero
  task automatic test_reset_defaults();
    send_hall_event(32'd100, HallAllLow);
    send_hall_event(32'd1, HallSect0);
    send_hall_event('0, HallAllHigh);
    send_hall_event('1, HallSect3);
    wait_drained();
  endtask

  task automatic test_sector_codes();
    write_all_regs('1, 32'd123456789, '0);
    send_hall_event(32'd1, HallSect0);
    send_hall_event('1, HallSect1);
    send_hall_event('0, HallSect2);
    send_hall_event(32'd3, HallSect3);
    send_hall_event(32'h8000_0000, HallSect4);
    send_hall_event(32'h7fff_ffff, HallSect5);
    send_hall_event(32'd7, HallAllLow);
    send_hall_event('0, HallAllHigh);
    wait_drained();
  endtask

  // Offset extremes wrap the sum; bad codes keep the last good angle
  task automatic test_phase_wrap();
    write_all_regs(32'd65536, '1, 16'h7fff);
    send_hall_event(32'd2, HallSect5);
    send_hall_event(32'd5, HallSect3);
    send_hall_event(32'd9, HallAllHigh);
    wait_drained();
    write_reg(CfgPhaseOffset, 32'hffff_8000);
    send_hall_event(32'd1, HallSect0);
    send_hall_event(32'd11, HallSect2);
    send_hall_event('0, HallAllLow);
    wait_drained();
  endtask

  // A write to the spare index changes nothing
  task automatic test_spare_index();
    write_reg(CfgSpare, DataW'($urandom));
    send_hall_event(32'd4, HallSect1);
    send_hall_event(32'd4, HallAllLow);
    wait_drained();
  endtask

  // Hold the output long enough for the block to stall its input
  task automatic test_backpressure();
    write_all_regs(rand_factor(), rand_factor(), AngleW'($urandom));
    hold_request = 400;
    repeat (8) send_hall_event(rand_period(), CodeW'($urandom_range(7)));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int unsigned gap_max;
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       write_all_regs('1, '1, 16'h7fff);
        1:       write_all_regs('0, '0, 16'h8000);
        default: write_all_regs(rand_factor(), rand_factor(), AngleW'($urandom));
      endcase
      case (ph % 4)
        0: begin
          stall_pct = 0;
          gap_max = 0;
        end
        1: begin
          stall_pct = 30;
          gap_max = 3;
        end
        2: begin
          stall_pct = 70;
          gap_max = 40;
        end
        default: begin
          stall_pct = $urandom_range(90);
          gap_max = $urandom_range(60);
        end
      endcase
      send_burst_traffic(PhaseItems, gap_max);
      wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_sector_codes();
    test_phase_wrap();
    test_spare_index();
    stall_pct = 40;
    test_backpressure();
    test_random_phases();
    stall_pct = 0;
    wait_drained();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("hall_angle_speed_estimator_core regression: pass");
    end else begin
      $display("hall_angle_speed_estimator_core regression: fail");
    end
    $finish;
  end

endmodule
